// ----- rtl/assert_macros.svh -----
// assertion helpers for the circle packing placer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property under clock with async reset masking
`define ASSERT_AR(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
		else $error("assertion failed");
// condition that must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_AR(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_AR(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/cpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg
// Types, constants and codes shared by the circle packing placer.
// ----------------------------------------------------------------------------
package cpp_pkg;

	localparam int MAX_CIRCLES = 256;
	localparam int CANVAS_SIZE = 1024;

	localparam int COORD_W  = 10;
	localparam int RAD_W    = 10;
	localparam int ATT_W    = 16;
	localparam int SLOT_W   = 9;
	localparam int STORED_W = 9;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 8;
	localparam int CNT_W    = $clog2(MAX_CIRCLES + 1);
	localparam int PH_W     = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int SQ_W     = 2 * (COORD_W + 1);

	// register indexes
	localparam logic [IDX_W-1:0] CFG_MIN_RADIUS    = 8'd0;
	localparam logic [IDX_W-1:0] CFG_MAX_RADIUS    = 8'd1;
	localparam logic [IDX_W-1:0] CFG_MAX_ATTEMPTS  = 8'd2;
	localparam logic [IDX_W-1:0] CFG_TOTAL_CIRCLES = 8'd3;

	typedef enum logic [1:0] {
		STAT_PLACED,
		STAT_RETRY,
		STAT_GIVEUP,
		STAT_FINISHED
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_STEP,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] cand_x;
		logic [COORD_W-1:0] cand_y;
	} in_t;

	typedef struct packed {
		status_t             status;
		logic [COORD_W-1:0]  circle_x;
		logic [COORD_W-1:0]  circle_y;
		logic [RAD_W-1:0]    radius;
		logic [STORED_W-1:0] circles_stored;
	} out_t;

	// one stored circle, also used for the probe
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [RAD_W-1:0]   r;
	} disc_t;

endpackage

// ----- rtl/cpp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_cell
// One slot of the circle ring: holds a circle and passes it to its neighbor.
// ----------------------------------------------------------------------------
module cpp_cell (
	input  logic          clk,
	input  logic          shift_en,
	input  logic          we,
	input  cpp_pkg::disc_t nxt,
	input  cpp_pkg::disc_t wdata,
	output cpp_pkg::disc_t q
);

	cpp_pkg::disc_t disc_q;

	// write has priority, ring is at rest while writing
	always_ff @(posedge clk) begin
		if (we) begin
			disc_q <= wdata;
		end else if (shift_en) begin
			disc_q <= nxt;
		end
	end

	assign q = disc_q;

endmodule

// ----- rtl/cpp_hit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_hit
// Pipelined collision test of the probe circle against one ring entry.
// ----------------------------------------------------------------------------
module cpp_hit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  cpp_pkg::disc_t probe,
	input  cpp_pkg::disc_t entry,
	output logic           hit
);

	localparam int CW = cpp_pkg::COORD_W;
	localparam int RW = cpp_pkg::RAD_W;
	localparam int SW = cpp_pkg::SQ_W;

	logic                 v_s1, v_s2;
	logic signed [CW:0]   dx_s1, dy_s1;
	logic [RW:0]          sum_s1;
	logic [SW-1:0]        dx2_s2, dy2_s2, sum2_s2;
	logic signed [SW-1:0] dx2_w, dy2_w;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: differences and radius sum
	always_ff @(posedge clk) begin
		dx_s1  <= $signed({1'b0, probe.x}) - $signed({1'b0, entry.x});
		dy_s1  <= $signed({1'b0, probe.y}) - $signed({1'b0, entry.y});
		sum_s1 <= {1'b0, probe.r} + {1'b0, entry.r};
	end

	assign dx2_w = dx_s1 * dx_s1;
	assign dy2_w = dy_s1 * dy_s1;

	// stage 2: squares
	always_ff @(posedge clk) begin
		dx2_s2  <= $unsigned(dx2_w);
		dy2_s2  <= $unsigned(dy2_w);
		sum2_s2 <= sum_s1 * sum_s1;
	end

	// touching counts as a collision
	assign hit = v_s2 && ({1'b0, sum2_s2} >= ({1'b0, dx2_s2} + {1'b0, dy2_s2}));

endmodule

// ----- rtl/circle_packing_placer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_packing_placer
// Greedy circle packing: tests candidate centres against a ring of stored
// circles and grows accepted circles by binary search on the radius.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  in        in    in_valid/in_ready    in_data  (cand_x, cand_y)
//  out       out   out_valid/out_ready  out_data (status, x, y, radius, count)
//  cfg       in    cfg_we               cfg_idx, cfg_wdata
//
//  each probe pass rotates the whole ring once
//  an item takes one pass for the minimum radius and up to ten more for the
//  radius search; a finished item skips the probe passes
//  one item is in work at a time; the result waits in an output register
//  reset clears counters and control, the ring contents are undefined
//  a stalled output holds the next result in a pending register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_packing_placer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cpp_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cpp_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [cpp_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [cpp_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int M   = cpp_pkg::MAX_CIRCLES;
	localparam int CW  = cpp_pkg::COORD_W;
	localparam int RW  = cpp_pkg::RAD_W;
	localparam int AW  = cpp_pkg::ATT_W;
	localparam int SLW = cpp_pkg::SLOT_W;
	localparam int NW  = cpp_pkg::CNT_W;
	localparam int PW  = cpp_pkg::PH_W;
	localparam logic [PW-1:0] LAST_PH = PW'(M - 1);

	function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
		logic [CW-1:0] res;
		res = v;
		if (int'(v) > cpp_pkg::CANVAS_SIZE - 1) res = CW'(cpp_pkg::CANVAS_SIZE - 1);
		return res;
	endfunction

	cpp_pkg::state_t state_q, state_n;

	logic [RW-1:0]  min_r_q, max_r_q;
	logic [AW-1:0]  max_att_q, att_q, att_n;
	logic [SLW-1:0] total_q, slots_q;
	logic [NW-1:0]  count_q;
	logic [PW-1:0]  phase_q;
	logic           drain_q;
	logic           acc_q;
	logic           first_q;
	logic [RW-1:0]  lo_q, hi_q;
	logic [RW:0]    mid_w;
	logic           search_w;
	logic           finished_w;
	cpp_pkg::disc_t probe_q;
	cpp_pkg::out_t  res_q, out_q;
	logic           out_valid_q;

	logic           shift_en, feed_valid, load_out, place;
	logic           hit;
	cpp_pkg::disc_t ring [M];
	cpp_pkg::disc_t wdisc;

	assign finished_w = (slots_q >= total_q) || (count_q >= NW'(M));
	assign search_w   = lo_q < hi_q;
	assign mid_w      = ({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1;
	assign att_n      = att_q + 1'b1;

	// ring of stored circles
	assign wdisc = '{x: probe_q.x, y: probe_q.y, r: lo_q};
	for (genvar i = 0; i < M; i++) begin : g_ring
		cpp_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.we       (place && (count_q == NW'(i))),
			.nxt      (ring[(i + 1) % M]),
			.wdata    (wdisc),
			.q        (ring[i])
		);
	end

	// collision test on the ring head
	cpp_hit u_hit (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (feed_valid),
		.probe  (probe_q),
		.entry  (ring[0]),
		.hit    (hit)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cpp_pkg::ST_IDLE: begin
				if (in_valid) state_n = finished_w ? cpp_pkg::ST_HOLD : cpp_pkg::ST_SCAN;
			end
			cpp_pkg::ST_SCAN: begin
				if (phase_q == LAST_PH) state_n = cpp_pkg::ST_DRAIN;
			end
			cpp_pkg::ST_DRAIN: begin
				if (drain_q) state_n = cpp_pkg::ST_EVAL;
			end
			cpp_pkg::ST_EVAL: begin
				state_n = (first_q && acc_q) ? cpp_pkg::ST_HOLD : cpp_pkg::ST_STEP;
			end
			cpp_pkg::ST_STEP: begin
				state_n = search_w ? cpp_pkg::ST_SCAN : cpp_pkg::ST_HOLD;
			end
			cpp_pkg::ST_HOLD: begin
				if (!out_valid_q || out_ready) state_n = cpp_pkg::ST_IDLE;
			end
			default: state_n = cpp_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready   = (state_q == cpp_pkg::ST_IDLE);
		shift_en   = (state_q == cpp_pkg::ST_SCAN);
		feed_valid = (state_q == cpp_pkg::ST_SCAN) && (NW'(phase_q) < count_q);
		load_out   = (state_q == cpp_pkg::ST_HOLD) && (!out_valid_q || out_ready);
		place      = (state_q == cpp_pkg::ST_STEP) && !search_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_r_q   <= RW'(2);
			max_r_q   <= RW'(50);
			max_att_q <= AW'(100);
			total_q   <= SLW'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cpp_pkg::CFG_MIN_RADIUS:    min_r_q   <= cfg_wdata[RW-1:0];
				cpp_pkg::CFG_MAX_RADIUS:    max_r_q   <= cfg_wdata[RW-1:0];
				cpp_pkg::CFG_MAX_ATTEMPTS:  max_att_q <= cfg_wdata[AW-1:0];
				cpp_pkg::CFG_TOTAL_CIRCLES: total_q   <= cfg_wdata[SLW-1:0];
				default: ;
			endcase
		end
	end

	// scan sequencing, counters and search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			drain_q <= 1'b0;
			acc_q   <= 1'b0;
			first_q <= 1'b0;
			count_q <= '0;
			att_q   <= '0;
			slots_q <= '0;
		end else begin
			unique case (state_q)
				cpp_pkg::ST_IDLE: begin
					acc_q   <= 1'b0;
					first_q <= 1'b1;
					drain_q <= 1'b0;
				end
				cpp_pkg::ST_SCAN: begin
					phase_q <= (phase_q == LAST_PH) ? '0 : phase_q + 1'b1;
					if (hit) acc_q <= 1'b1;
				end
				cpp_pkg::ST_DRAIN: begin
					drain_q <= 1'b1;
					if (hit) acc_q <= 1'b1;
				end
				cpp_pkg::ST_EVAL: begin
					drain_q <= 1'b0;
					first_q <= 1'b0;
					acc_q   <= 1'b0;
					if (first_q && acc_q) begin
						if (att_n >= max_att_q || att_n == '0) begin
							att_q   <= '0;
							slots_q <= slots_q + 1'b1;
						end else begin
							att_q <= att_n;
						end
					end
				end
				cpp_pkg::ST_STEP: begin
					if (!search_w) begin
						count_q <= count_q + 1'b1;
						att_q   <= '0;
						slots_q <= slots_q + 1'b1;
					end
				end
				cpp_pkg::ST_HOLD: ;
				default: ;
			endcase
		end
	end

	// probe, search bounds and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			cpp_pkg::ST_IDLE: begin
				probe_q <= '{x: clamp(in_data.cand_x), y: clamp(in_data.cand_y), r: min_r_q};
				res_q   <= '{status: cpp_pkg::STAT_FINISHED,
					circle_x: clamp(in_data.cand_x), circle_y: clamp(in_data.cand_y),
					radius: '0, circles_stored: cpp_pkg::STORED_W'(count_q)};
			end
			cpp_pkg::ST_EVAL: begin
				if (first_q) begin
					if (acc_q) begin
						res_q.status <= (att_n >= max_att_q || att_n == '0) ?
							cpp_pkg::STAT_GIVEUP : cpp_pkg::STAT_RETRY;
					end else begin
						lo_q <= min_r_q;
						hi_q <= (max_r_q > min_r_q) ? max_r_q - 1'b1 : min_r_q;
					end
				end else if (acc_q) begin
					hi_q <= probe_q.r - 1'b1;
				end else begin
					lo_q <= probe_q.r;
				end
			end
			cpp_pkg::ST_STEP: begin
				probe_q.r <= mid_w[RW-1:0];
				if (!search_w) begin
					res_q.status         <= cpp_pkg::STAT_PLACED;
					res_q.radius         <= lo_q;
					res_q.circles_stored <= cpp_pkg::STORED_W'(count_q + 1'b1);
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`ASSERT_AR(a_ring_home, clk, arst_n, (state_q != cpp_pkg::ST_SCAN) |-> (phase_q == '0))
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > NW'(M))
	`ASSERT_AR(a_place_count, clk, arst_n, place |=> (count_q == $past(count_q) + 1'b1))
	`ASSERT_AR(a_scan_end, clk, arst_n, (state_q == cpp_pkg::ST_SCAN && phase_q == LAST_PH) |=> (state_q == cpp_pkg::ST_DRAIN))

endmodule
